// ===== hw/rtl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types, constants and segment tables of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int COORD_W = 11;   // signed center coordinate
  localparam int RAD_W   = 9;    // radius and offsets
  localparam int SUM_W   = 12;   // center plus or minus offset
  localparam int PIX_W   = 10;   // clipped pixel coordinate
  localparam int DIM_W   = 11;   // screen size register
  localparam int DEC_W   = 12;   // decision and delta_y

  localparam logic [DIM_W-1:0] SCREEN_LIMIT = 11'd1024;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // request opcodes
  localparam logic [1:0] OP_START_LINE = 2'd0;
  localparam logic [1:0] OP_START_FILL = 2'd1;
  localparam logic [1:0] OP_STEP       = 2'd2;

  // job kinds handed to the back end
  localparam logic [1:0] MODE_START_LINE = 2'd0;
  localparam logic [1:0] MODE_START_FILL = 2'd1;
  localparam logic [1:0] MODE_STEP_LINE  = 2'd2;
  localparam logic [1:0] MODE_STEP_FILL  = 2'd3;

  // offset source of one segment end
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_A    = 2'd1;
  localparam logic [1:0] SRC_B    = 2'd2;

  typedef struct packed {
    logic       neg;
    logic [1:0] src;
  } term_t;

  typedef struct packed {
    term_t xa;
    term_t xb;
    term_t ya;
    term_t yb;
  } seg_terms_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          a;     // off_x, zero on a start
    logic [RAD_W-1:0]          b;     // off_y, the radius on a start
    logic [1:0]                mode;
    logic                      finished;
  } job_t;

  localparam term_t T_0  = '{neg: 1'b0, src: SRC_ZERO};
  localparam term_t T_PA = '{neg: 1'b0, src: SRC_A};
  localparam term_t T_NA = '{neg: 1'b1, src: SRC_A};
  localparam term_t T_PB = '{neg: 1'b0, src: SRC_B};
  localparam term_t T_NB = '{neg: 1'b1, src: SRC_B};

  function automatic seg_terms_t span(input term_t xa, input term_t xb,
                                      input term_t ya, input term_t yb);
    seg_terms_t s;
    s.xa = xa;
    s.xb = xb;
    s.ya = ya;
    s.yb = yb;
    return s;
  endfunction

  // index of the final segment of a job
  function automatic logic [2:0] seg_last(input logic [1:0] mode);
    logic [2:0] n;
    case (mode)
      MODE_START_LINE: n = 3'd3;
      MODE_START_FILL: n = 3'd1;
      MODE_STEP_LINE:  n = 3'd7;
      default:         n = 3'd3;
    endcase
    return n;
  endfunction

  // segment ends as center plus or minus an offset
  function automatic seg_terms_t seg_terms(input logic [1:0] mode, input logic [2:0] idx);
    seg_terms_t s;
    case (mode)
      MODE_START_LINE: begin
        case (idx[1:0])
          2'd0:    s = span(T_0, T_0, T_PB, T_PB);
          2'd1:    s = span(T_0, T_0, T_NB, T_NB);
          2'd2:    s = span(T_PB, T_PB, T_0, T_0);
          default: s = span(T_NB, T_NB, T_0, T_0);
        endcase
      end
      MODE_START_FILL: begin
        case (idx[0])
          1'b0:    s = span(T_0, T_0, T_NB, T_PB);
          default: s = span(T_NB, T_PB, T_0, T_0);
        endcase
      end
      MODE_STEP_LINE: begin
        case (idx)
          3'd0:    s = span(T_PA, T_PA, T_PB, T_PB);
          3'd1:    s = span(T_NA, T_NA, T_PB, T_PB);
          3'd2:    s = span(T_PA, T_PA, T_NB, T_NB);
          3'd3:    s = span(T_NA, T_NA, T_NB, T_NB);
          3'd4:    s = span(T_PB, T_PB, T_PA, T_PA);
          3'd5:    s = span(T_NB, T_NB, T_PA, T_PA);
          3'd6:    s = span(T_PB, T_PB, T_NA, T_NA);
          default: s = span(T_NB, T_NB, T_NA, T_NA);
        endcase
      end
      default: begin
        case (idx[1:0])
          2'd0:    s = span(T_NB, T_PB, T_PA, T_PA);
          2'd1:    s = span(T_NB, T_PB, T_NA, T_NA);
          2'd2:    s = span(T_PA, T_PA, T_NB, T_PB);
          default: s = span(T_NA, T_NA, T_NB, T_PB);
        endcase
      end
    endcase
    return s;
  endfunction

  // center plus or minus the selected offset
  function automatic logic signed [SUM_W-1:0] term_value(
      input logic signed [COORD_W-1:0] c, input logic [RAD_W-1:0] a,
      input logic [RAD_W-1:0] b, input term_t t);
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] off;
    base = {c[COORD_W-1], c};
    case (t.src)
      SRC_A:   off = $signed({3'b000, a});
      SRC_B:   off = $signed({3'b000, b});
      default: off = '0;
    endcase
    return t.neg ? base - off : base + off;
  endfunction

endpackage

// ===== hw/rtl/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Takes commands, runs the midpoint decision update and queues segment jobs.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; #(
  parameter int MAX_RADIUS = 511
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic [RAD_W-1:0]          radius,
  input  logic                      q_full,
  output logic                      push,
  output job_t                      push_job
);

  localparam int RAD_TOP = (1 << RAD_W) - 1;
  localparam int RAD_CAP = (MAX_RADIUS < RAD_TOP) ? MAX_RADIUS : RAD_TOP;

  logic signed [COORD_W-1:0] ctr_x, ctr_x_next;
  logic signed [COORD_W-1:0] ctr_y, ctr_y_next;
  logic [RAD_W-1:0]          off_x, off_x_next;
  logic [RAD_W-1:0]          off_y, off_y_next;
  logic signed [DEC_W-1:0]   decision, decision_next;
  logic [COORD_W-1:0]        delta_x, delta_x_next;
  logic signed [DEC_W-1:0]   delta_y, delta_y_next;
  logic                      fill_mode, fill_mode_next;
  logic                      active, active_next;

  logic                      accept;
  logic                      is_start;
  logic [RAD_W-1:0]          r_sat;
  logic                      go_down;
  logic [RAD_W-1:0]          ox1, oy1;
  logic signed [DEC_W-1:0]   dy1, dec1, dec2;
  logic [COORD_W-1:0]        dx1;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign is_start = (opcode == OP_START_LINE) || (opcode == OP_START_FILL);
  assign r_sat    = (radius > RAD_W'(RAD_CAP)) ? RAD_W'(RAD_CAP) : radius;

  // one iteration of the midpoint loop
  assign go_down = !decision[DEC_W-1];
  assign oy1     = go_down ? off_y - 1'b1 : off_y;
  assign dy1     = go_down ? delta_y + 12'sd2 : delta_y;
  assign dec1    = go_down ? decision + dy1 : decision;
  assign ox1     = off_x + 1'b1;
  assign dx1     = delta_x + 11'd2;
  assign dec2    = dec1 + $signed({1'b0, dx1});

  // next state and job
  always_comb begin
    ctr_x_next     = ctr_x;
    ctr_y_next     = ctr_y;
    off_x_next     = off_x;
    off_y_next     = off_y;
    decision_next  = decision;
    delta_x_next   = delta_x;
    delta_y_next   = delta_y;
    fill_mode_next = fill_mode;
    active_next    = active;
    push           = 1'b0;
    push_job.cx       = ctr_x;
    push_job.cy       = ctr_y;
    push_job.a        = ox1;
    push_job.b        = oy1;
    push_job.mode     = fill_mode ? MODE_STEP_FILL : MODE_STEP_LINE;
    push_job.finished = !(ox1 < oy1);
    if (accept && is_start) begin
      ctr_x_next     = center_x;
      ctr_y_next     = center_y;
      off_x_next     = '0;
      off_y_next     = r_sat;
      decision_next  = 12'sd1 - $signed({3'b000, r_sat});
      delta_x_next   = 11'd1;
      delta_y_next   = -$signed({2'b00, r_sat, 1'b0});
      fill_mode_next = (opcode == OP_START_FILL);
      active_next    = (r_sat != '0);
      push           = 1'b1;
      push_job.cx       = center_x;
      push_job.cy       = center_y;
      push_job.a        = '0;
      push_job.b        = r_sat;
      push_job.mode     = (opcode == OP_START_FILL) ? MODE_START_FILL : MODE_START_LINE;
      push_job.finished = (r_sat == '0);
    end else if (accept && (opcode == OP_STEP) && active) begin
      off_x_next    = ox1;
      off_y_next    = oy1;
      decision_next = dec2;
      delta_x_next  = dx1;
      delta_y_next  = dy1;
      active_next   = (ox1 < oy1);
      push          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_x     <= '0;
      ctr_y     <= '0;
      off_x     <= '0;
      off_y     <= '0;
      decision  <= '0;
      delta_x   <= 11'd1;
      delta_y   <= '0;
      fill_mode <= 1'b0;
      active    <= 1'b0;
    end else begin
      ctr_x     <= ctr_x_next;
      ctr_y     <= ctr_y_next;
      off_x     <= off_x_next;
      off_y     <= off_y_next;
      decision  <= decision_next;
      delta_x   <= delta_x_next;
      delta_y   <= delta_y_next;
      fill_mode <= fill_mode_next;
      active    <= active_next;
    end
  end

endmodule

// ===== hw/rtl/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// mcr_queue
// Short job queue that decouples command intake from segment output.
// ----------------------------------------------------------------------------
module mcr_queue import mcr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output logic          head_valid,
  output job_t          head_job,
  output logic          full,
  output logic [Q_AW:0] level
);

  job_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign level      = count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Walks the segments of each job, clips them to the screen, registers output.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  job_t             head_job,
  output logic             pop,
  input  logic [DIM_W-1:0] screen_width,
  input  logic [DIM_W-1:0] screen_height,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] seg_x_lo,
  output logic [PIX_W-1:0] seg_y_lo,
  output logic [PIX_W-1:0] seg_x_hi,
  output logic [PIX_W-1:0] seg_y_hi,
  output logic             visible,
  output logic             finished,
  output logic             last_of_run
);

  logic [2:0]              idx;
  logic                    out_ok;
  logic                    fire;
  logic                    last;
  seg_terms_t              terms;
  logic signed [SUM_W-1:0] xa, xb, ya, yb;
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic signed [SUM_W:0]   wm1, hm1;
  logic signed [SUM_W:0]   xa_e, xb_e, ya_e, yb_e;
  logic                    vis;
  logic [PIX_W-1:0]        x_lo, y_lo, x_hi, y_hi;

  assign out_ok = !out_valid || out_ready;
  assign fire   = head_valid && out_ok;
  assign last   = (idx == seg_last(head_job.mode));
  assign pop    = fire && last;

  // segment ends of the current index
  assign terms = seg_terms(head_job.mode, idx);
  assign xa    = term_value(head_job.cx, head_job.a, head_job.b, terms.xa);
  assign xb    = term_value(head_job.cx, head_job.a, head_job.b, terms.xb);
  assign ya    = term_value(head_job.cy, head_job.a, head_job.b, terms.ya);
  assign yb    = term_value(head_job.cy, head_job.a, head_job.b, terms.yb);

  // clip against the screen
  assign w_eff = (screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width;
  assign h_eff = (screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height;
  assign wm1   = $signed({2'b00, w_eff}) - 13'sd1;
  assign hm1   = $signed({2'b00, h_eff}) - 13'sd1;
  assign xa_e  = {xa[SUM_W-1], xa};
  assign xb_e  = {xb[SUM_W-1], xb};
  assign ya_e  = {ya[SUM_W-1], ya};
  assign yb_e  = {yb[SUM_W-1], yb};
  assign vis   = (w_eff != '0) && (h_eff != '0) && (xa_e <= wm1) && !xb[SUM_W-1] &&
                 (ya_e <= hm1) && !yb[SUM_W-1];
  assign x_lo  = xa[SUM_W-1] ? '0 : xa[PIX_W-1:0];
  assign y_lo  = ya[SUM_W-1] ? '0 : ya[PIX_W-1:0];
  assign x_hi  = (xb_e > wm1) ? wm1[PIX_W-1:0] : xb[PIX_W-1:0];
  assign y_hi  = (yb_e > hm1) ? hm1[PIX_W-1:0] : yb[PIX_W-1:0];

  // segment index within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      seg_x_lo    <= vis ? x_lo : '0;
      seg_y_lo    <= vis ? y_lo : '0;
      seg_x_hi    <= vis ? x_hi : '0;
      seg_y_hi    <= vis ? y_hi : '0;
      visible     <= vis;
      finished    <= head_job.finished;
      last_of_run <= last;
    end
  end

endmodule

// ===== hw/rtl/midpoint_circle_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle rasterizer producing screen-clipped axis-aligned segments.
// ----------------------------------------------------------------------------
// A start request (opcode 0 outline, 1 filled) loads center and radius and
// yields four cardinal pixels or two diameter spans; each advance request
// (opcode 2) runs one midpoint iteration and yields eight pixels or four
// spans. Opcode 3, and an advance with no circle in progress, yield nothing.
// The front end takes one request per cycle while its four-entry job queue
// has room; the back end clips and registers one segment per cycle while
// the segment stream is not stalled. When the queue is empty, a request is
// written into the job queue and its first segment is then registered in
// the output register before it is presented on the segment stream. The
// last segment of each request carries tlast. Screen width and height are
// to be written over the register port at byte addresses 0 and 4 only
// while the unit is idle; the block itself does not enforce this.
module midpoint_circle_rasterizer_unit import mcr_pkg::*; #(
  parameter int MAX_RADIUS = 511
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // center_x[10:0], center_y[21:11], radius[30:22], zero
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  // segment stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // seg_x_lo[9:0], seg_y_lo[19:10], seg_x_hi[29:20],
                                 // seg_y_hi[39:30]
  output logic [1:0]  m_tuser,   // visible[0], finished[1]
  output logic        m_tlast,   // last_of_run
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;

  logic             push;
  job_t             push_job;
  logic             pop;
  logic             head_valid;
  job_t             head_job;
  logic             q_full;
  logic [Q_AW:0]    q_level;

  logic [PIX_W-1:0] seg_x_lo, seg_y_lo, seg_x_hi, seg_y_hi;
  logic             visible, finished, last_of_run;

  // register port
  assign pready = 1'b1;
  assign prdata = {21'd0, paddr[2] ? screen_height : screen_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 11'd320;
      screen_height <= 11'd240;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        screen_height <= pwdata[DIM_W-1:0];
      end else begin
        screen_width <= pwdata[DIM_W-1:0];
      end
    end
  end

  mcr_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .opcode   (s_tuser),
    .center_x ($signed(s_tdata[10:0])),
    .center_y ($signed(s_tdata[21:11])),
    .radius   (s_tdata[30:22]),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  mcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (q_full),
    .level      (q_level)
  );

  mcr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .seg_x_lo      (seg_x_lo),
    .seg_y_lo      (seg_y_lo),
    .seg_x_hi      (seg_x_hi),
    .seg_y_hi      (seg_y_hi),
    .visible       (visible),
    .finished      (finished),
    .last_of_run   (last_of_run)
  );

  assign m_tdata = {seg_y_hi, seg_x_hi, seg_y_lo, seg_x_lo};
  assign m_tuser = {finished, visible};
  assign m_tlast = last_of_run;

  // queue never overfills
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_level <= (Q_AW+1)'(Q_DEPTH))
    else $error("job queue level beyond depth");

  // a hidden segment carries zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("hidden segment with nonzero coordinates");

  // a visible segment is ordered on both axes
  a_seg_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[9:0] <= m_tdata[29:20]) &&
                               (m_tdata[19:10] <= m_tdata[39:30]))
    else $error("visible segment with lo above hi");

  // a pop only happens together with an emitted segment
  a_pop_emits: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid && m_tlast)
    else $error("job retired without final segment");

endmodule
